[design/lzw_byte_compressor_core_assert.svh]
// ----------------------------------------------------------------------------
// LZW byte compressor assertion macros
// Shared property forms for the core's checks.
// ----------------------------------------------------------------------------
`ifndef LZW_BYTE_COMPRESSOR_CORE_ASSERT_SVH
`define LZW_BYTE_COMPRESSOR_CORE_ASSERT_SVH

// same-cycle implication
`define LBC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbc check failed: lbl");

// next-cycle implication
`define LBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbc check failed: lbl");

`endif

[design/lbc_pkg.sv]
// ----------------------------------------------------------------------------
// LZW byte compressor package
// Sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package lbc_pkg;
    localparam int TABLE_ENTRIES = 65536;
    localparam int CODE_WIDTH    = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int KEY_W         = CODE_WIDTH + 8;
    localparam int NEXT_W        = CODE_WIDTH + 1;
    localparam int ENTRY_W       = 1 + KEY_W + CODE_WIDTH;
    localparam int CFG_IDX_W     = 1;

    localparam logic [31:0] HASH_MULT    = 32'd2654435761;
    localparam logic [15:0] RESET_MARKER = 16'hFFFE;
    localparam logic [NEXT_W-1:0] FIRST_FREE = NEXT_W'(256);
    localparam logic [15:0] CODE_LIMIT_RST = 16'hEFFF;
    localparam logic [15:0] RESET_INT_RST  = 16'd768;

    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LIMIT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_INTERVAL = 1'd1;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_BOUNDARY = 2'd1;
    localparam logic [1:0] KIND_FLUSH    = 2'd2;

    typedef struct packed {
        logic latch_in;
        logic set_first;
        logic calc_hash;
        logic mark_free;
        logic step;
        logic insert;
        logic take_hit;
        logic start_new;
        logic push_cur;
        logic push_mark;
        logic last;
        logic dict_clear;
        logic clear_wr;
        logic bc_inc;
    } lbc_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       string_valid;
        logic       bc_match;
        logic       ent_valid;
        logic       key_match;
        logic       probe_full;
        logic       out_free;
        logic       clear_done;
    } lbc_sts_t;
endpackage
`default_nettype wire

[design/lbc_ram.sv]
// ----------------------------------------------------------------------------
// LZW byte compressor generic RAM
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[design/lbc_ctrl.sv]
// ----------------------------------------------------------------------------
// LZW byte compressor controller
// Sequences decode, probing, insertion, emission and clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module lbc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_accept,
    input  wire lbc_pkg::lbc_sts_t sts,
    output logic                   idle,
    output lbc_pkg::lbc_cmd_t      cmd
);
    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_DECODE  = 10'b0000000100,
        S_READ    = 10'b0000001000,
        S_CHECK   = 10'b0000010000,
        S_MISS    = 10'b0000100000,
        S_EMIT_MS = 10'b0001000000,
        S_EMIT_BC = 10'b0010000000,
        S_EMIT_MK = 10'b0100000000,
        S_EMIT_FL = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign idle = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.kind)
                    lbc_pkg::KIND_DATA:
                    begin
                        if (!sts.string_valid)
                        begin
                            cmd.set_first = 1'b1;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            cmd.calc_hash = 1'b1;
                            state_next    = S_READ;
                        end
                    end
                    lbc_pkg::KIND_BOUNDARY:
                    begin
                        if (sts.bc_match)
                        begin
                            state_next = sts.string_valid ? S_EMIT_BC : S_EMIT_MK;
                        end
                        else
                        begin
                            cmd.bc_inc = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    lbc_pkg::KIND_FLUSH:
                    begin
                        state_next = sts.string_valid ? S_EMIT_FL : S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!sts.ent_valid)
                begin
                    cmd.mark_free = 1'b1;
                    state_next    = S_MISS;
                end
                else if (sts.key_match)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (sts.probe_full)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_MISS:
            begin
                cmd.insert = 1'b1;
                state_next = S_EMIT_MS;
            end
            S_EMIT_MS:
            begin
                if (sts.out_free)
                begin
                    cmd.push_cur  = 1'b1;
                    cmd.last      = 1'b1;
                    cmd.start_new = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EMIT_BC:
            begin
                if (sts.out_free)
                begin
                    cmd.push_cur = 1'b1;
                    state_next   = S_EMIT_MK;
                end
            end
            S_EMIT_MK:
            begin
                if (sts.out_free)
                begin
                    cmd.push_mark  = 1'b1;
                    cmd.last       = 1'b1;
                    cmd.dict_clear = 1'b1;
                    state_next     = S_CLEAR;
                end
            end
            S_EMIT_FL:
            begin
                if (sts.out_free)
                begin
                    cmd.push_cur = 1'b1;
                    cmd.last     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end
endmodule
`default_nettype wire

[design/lbc_datapath.sv]
// ----------------------------------------------------------------------------
// LZW byte compressor datapath
// String state, hashing, dictionary RAM, config registers and output stage.
// ----------------------------------------------------------------------------
`default_nettype none
module lbc_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lbc_pkg::lbc_cmd_t                 cmd,
    output lbc_pkg::lbc_sts_t                      sts,
    input  wire logic [1:0]                        kind,
    input  wire logic [7:0]                        data_byte,
    input  wire logic                              cfg_write,
    input  wire logic [lbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [15:0]                       cfg_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [15:0]                            out_code,
    output logic                                   out_last
);
    logic [1:0]                         kind_reg;
    logic [7:0]                         byte_reg;
    logic [lbc_pkg::CODE_WIDTH-1:0]     current_reg;
    logic                               sv_reg;
    logic [lbc_pkg::NEXT_W-1:0]         next_code_reg;
    logic [15:0]                        bc_reg;
    logic [15:0]                        code_limit_reg;
    logic [15:0]                        reset_int_reg;
    logic [lbc_pkg::IDX_W-1:0]          slot_reg;
    logic [lbc_pkg::IDX_W-1:0]          cnt_reg;
    logic                               free_reg;
    logic [lbc_pkg::IDX_W-1:0]          clr_addr_reg;
    logic                               out_valid_reg;
    logic [15:0]                        out_code_reg;
    logic                               out_last_reg;

    logic [lbc_pkg::KEY_W-1:0]          key;
    logic [31:0]                        prod;
    logic [31:0]                        hash;
    logic [16:0]                        lim17;
    logic [16:0]                        cap17;
    logic [16:0]                        eff17;
    logic                               code_ok;
    logic                               ram_we;
    logic [lbc_pkg::IDX_W-1:0]          ram_addr;
    logic [lbc_pkg::ENTRY_W-1:0]        ram_wdata;
    logic [lbc_pkg::ENTRY_W-1:0]        ram_rdata;
    logic [lbc_pkg::KEY_W-1:0]          ent_key;
    logic [lbc_pkg::CODE_WIDTH-1:0]     ent_code;
    logic                               out_free;

    assign key   = {current_reg, byte_reg};
    assign prod  = 32'(key) * lbc_pkg::HASH_MULT;
    assign hash  = prod ^ (32'(key) >> 11);
    assign lim17 = {1'b0, code_limit_reg};
    assign cap17 = 17'(1) << lbc_pkg::CODE_WIDTH;
    assign eff17 = (lim17 < cap17) ? lim17 : cap17;
    assign code_ok = (17'(next_code_reg) < eff17);

    assign ent_key  = ram_rdata[lbc_pkg::ENTRY_W-2 -: lbc_pkg::KEY_W];
    assign ent_code = ram_rdata[lbc_pkg::CODE_WIDTH-1:0];
    assign out_free = !out_valid_reg || !out_stall;

    assign ram_we    = cmd.clear_wr || (cmd.insert && free_reg && code_ok);
    assign ram_addr  = cmd.clear_wr ? clr_addr_reg : slot_reg;
    assign ram_wdata = cmd.clear_wr ? '0
                     : {1'b1, key, next_code_reg[lbc_pkg::CODE_WIDTH-1:0]};

    lbc_ram #(
        .WIDTH(lbc_pkg::ENTRY_W),
        .DEPTH(lbc_pkg::TABLE_ENTRIES)
    ) u_dict (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        sts.kind         = kind_reg;
        sts.string_valid = sv_reg;
        sts.bc_match     = (bc_reg == reset_int_reg);
        sts.ent_valid    = ram_rdata[lbc_pkg::ENTRY_W-1];
        sts.key_match    = (ent_key == key);
        sts.probe_full   = &cnt_reg;
        sts.out_free     = out_free;
        sts.clear_done   = &clr_addr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            kind_reg <= kind;
            byte_reg <= data_byte;
        end
        if (cmd.calc_hash)
        begin
            slot_reg <= hash[lbc_pkg::IDX_W-1:0];
            cnt_reg  <= '0;
        end
        else if (cmd.step)
        begin
            slot_reg <= slot_reg + 1'b1;
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (cmd.push_cur || cmd.push_mark)
        begin
            out_code_reg <= cmd.push_mark ? lbc_pkg::RESET_MARKER : 16'(current_reg);
            out_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_reg    <= '0;
            sv_reg         <= 1'b0;
            next_code_reg  <= lbc_pkg::FIRST_FREE;
            bc_reg         <= '0;
            code_limit_reg <= lbc_pkg::CODE_LIMIT_RST;
            reset_int_reg  <= lbc_pkg::RESET_INT_RST;
            free_reg       <= 1'b0;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    lbc_pkg::CFG_CODE_LIMIT:     code_limit_reg <= cfg_data;
                    lbc_pkg::CFG_RESET_INTERVAL: reset_int_reg  <= cfg_data;
                    default:                     ;
                endcase
            end
            if (cmd.set_first || cmd.start_new)
            begin
                current_reg <= lbc_pkg::CODE_WIDTH'(byte_reg);
                sv_reg      <= 1'b1;
            end
            else if (cmd.take_hit)
            begin
                current_reg <= ent_code;
            end
            else if (cmd.dict_clear)
            begin
                current_reg <= '0;
                sv_reg      <= 1'b0;
            end
            if (cmd.dict_clear)
            begin
                next_code_reg <= lbc_pkg::FIRST_FREE;
                bc_reg        <= '0;
            end
            else
            begin
                if (cmd.insert && free_reg && code_ok)
                begin
                    next_code_reg <= next_code_reg + 1'b1;
                end
                if (cmd.bc_inc)
                begin
                    bc_reg <= bc_reg + 16'd1;
                end
            end
            if (cmd.calc_hash)
            begin
                free_reg <= 1'b0;
            end
            else if (cmd.mark_free)
            begin
                free_reg <= 1'b1;
            end
            if (cmd.dict_clear)
            begin
                clr_addr_reg <= '0;
            end
            else if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.push_cur || cmd.push_mark)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_code  = out_code_reg;
    assign out_last  = out_last_reg;
endmodule
`default_nettype wire

[design/lzw_byte_compressor_core.sv]
// ----------------------------------------------------------------------------
// LZW byte compressor core
// LZW encoder with hashed dictionary, periodic reset marker and flush.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        sink       in_valid / in_stall  kind, data_byte
// out       source     out_valid/out_stall  code, last
// cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Data byte: an empty string starts from the byte; else the key is hashed and
// probe slots are read (RAM port) and checked; a miss inserts, then emits.
// Boundary and flush: any code waits on the output register to be free.
// After reset and after each dictionary reset the RAM is swept.
// in_stall stays high while an item is in work; out_stall holds the result.
// ----------------------------------------------------------------------------
`default_nettype none
module lzw_byte_compressor_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    kind,
    input  wire logic [7:0]                    data_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [15:0]                        code,
    output logic                               last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                   cfg_data
);
    `include "lzw_byte_compressor_core_assert.svh"

    lbc_pkg::lbc_cmd_t cmd;
    lbc_pkg::lbc_sts_t sts;
    logic              idle;
    logic              in_accept;

    assign in_stall  = !idle;
    assign in_accept = in_valid && idle;
    assign cfg_ready = 1'b1;

    lbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_accept(in_accept),
        .sts      (sts),
        .idle     (idle),
        .cmd      (cmd)
    );

    lbc_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .kind     (kind),
        .data_byte(data_byte),
        .cfg_write(cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_code (code),
        .out_last (last)
    );

    `LBC_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)
    `LBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(code))
    `LBC_ASSERT_IMPL(a_one_push, cmd.push_cur || cmd.push_mark, !(cmd.push_cur && cmd.push_mark))
endmodule
`default_nettype wire
